// ===== src/dtvs_pkg.sv =====
// Shared constants, codes and control types of the discrete table variate sampler.
package dtvs_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;
  localparam logic CFG_IDX_ENTRY_COUNT = 1'b0;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CDF    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  // Control that travels with a wave along the cell row.
  typedef struct packed {
    logic valid;
    logic walk;   // 0: sum pass, 1: sample walk pass
  } wave_ctl_t;

  // Start request to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic div;    // 0: scale multiply, 1: cdf division
  } md_ctl_t;

endpackage

// ===== src/dtvs_cell.sv =====
// One table slot of the sampler: holds a (value, weight) pair and advances the wave by one cell.
module dtvs_cell #(
  parameter int CELL_ID    = 0,
  parameter int VALUE_BITS = dtvs_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = dtvs_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS   = FRAC_BITS + 4,
  parameter int SEL_BITS   = dtvs_pkg::IDX_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  active,
  input  logic                  ld_en,
  input  logic [SEL_BITS-1:0]   ld_idx,
  input  logic [VALUE_BITS-1:0] ld_value,
  input  logic [FRAC_BITS-1:0]  ld_weight,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [VALUE_BITS-1:0] right_value,
  input  logic [VALUE_BITS-1:0] query,
  input  dtvs_pkg::wave_ctl_t   ctl_in,
  input  logic [ACC_BITS-1:0]   acc_in,
  input  logic [ACC_BITS-1:0]   csum_in,
  input  logic                  found_in,
  input  logic [VALUE_BITS-1:0] val_in,
  output logic [VALUE_BITS-1:0] value,
  output logic                  ld_ok,
  output dtvs_pkg::wave_ctl_t   ctl_out,
  output logic [ACC_BITS-1:0]   acc_out,
  output logic [ACC_BITS-1:0]   csum_out,
  output logic                  found_out,
  output logic [VALUE_BITS-1:0] val_out
);

  logic [VALUE_BITS-1:0] value_r;
  logic [FRAC_BITS-1:0]  weight_r;
  dtvs_pkg::wave_ctl_t   ctl_r;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [ACC_BITS-1:0]   csum_r, csum_nxt;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [ACC_BITS-1:0]   w_ext;

  assign w_ext = ACC_BITS'(weight_r);

  // Strictly increasing check against both neighbors; an empty slot above imposes no bound.
  assign ld_ok = ld_en && (ld_idx == SEL_BITS'(CELL_ID)) && (ld_value > left_value) &&
                 ((right_value == '0) || (ld_value < right_value));

  always_comb begin
    acc_nxt   = acc_in;
    csum_nxt  = csum_in;
    found_nxt = found_in;
    val_nxt   = val_in;
    if (ctl_in.walk) begin
      if (active && !found_in) begin
        if (acc_in < w_ext) begin
          found_nxt = 1'b1;
          val_nxt   = value_r;
        end else begin
          acc_nxt = acc_in - w_ext;
        end
      end
    end else if (active) begin
      acc_nxt = acc_in + w_ext;
      if (value_r <= query) begin
        csum_nxt = csum_in + w_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= '0;
      weight_r <= '0;
      ctl_r    <= '0;
    end else begin
      ctl_r <= ctl_in;
      if (ld_ok) begin
        value_r  <= ld_value;
        weight_r <= ld_weight;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    csum_r  <= csum_nxt;
    found_r <= found_nxt;
    val_r   <= val_nxt;
  end

  assign value     = value_r;
  assign ctl_out   = ctl_r;
  assign acc_out   = acc_r;
  assign csum_out  = csum_r;
  assign found_out = found_r;
  assign val_out   = val_r;

endmodule

// ===== src/dtvs_muldiv.sv =====
// Shared bit-serial unit: scale multiply for sampling and restoring division for the cdf.
module dtvs_muldiv #(
  parameter int FRAC_BITS = dtvs_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS  = FRAC_BITS + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtvs_pkg::md_ctl_t    ctl,
  input  logic [FRAC_BITS-1:0] frac,
  input  logic [ACC_BITS-1:0]  num,
  input  logic [ACC_BITS-1:0]  den,
  output logic                 done,
  output logic [ACC_BITS-1:0]  prod,
  output logic [FRAC_BITS:0]   quot
);

  localparam int AW    = FRAC_BITS + ACC_BITS;
  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic             busy_r, busy_nxt;
  logic             div_r, div_nxt;
  logic             first_r, first_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [FRAC_BITS:0] b_r, b_nxt;
  logic [ACC_BITS-1:0] t_r, t_nxt;
  logic [AW-1:0]    sh;
  logic [AW-1:0]    t_ext;

  assign t_ext = AW'(t_r);
  assign sh    = first_r ? a_r : (a_r << 1);

  always_comb begin
    busy_nxt  = busy_r;
    div_nxt   = div_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    t_nxt     = t_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      div_nxt   = ctl.div;
      first_nxt = 1'b1;
      t_nxt     = den;
      if (ctl.div) begin
        a_nxt   = AW'(num);
        b_nxt   = '0;
        cnt_nxt = CNT_W'(FRAC_BITS + 1);
      end else begin
        a_nxt   = '0;
        b_nxt   = {1'b0, frac};
        cnt_nxt = CNT_W'(FRAC_BITS);
      end
    end else if (busy_r) begin
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r - 1'b1;
      if (div_r) begin
        if (sh >= t_ext) begin
          a_nxt = sh - t_ext;
          b_nxt = {b_r[FRAC_BITS-1:0], 1'b1};
        end else begin
          a_nxt = sh;
          b_nxt = {b_r[FRAC_BITS-1:0], 1'b0};
        end
      end else begin
        // MSB first: shift the product, add the total for each set fraction bit
        a_nxt = (a_r << 1) + (b_r[FRAC_BITS-1] ? t_ext : '0);
        b_nxt = b_r << 1;
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    first_r <= first_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    t_r     <= t_nxt;
  end

  assign done = done_r;
  assign prod = a_r[AW-1:FRAC_BITS];
  assign quot = b_r;

endmodule

// ===== src/discrete_table_variate_sampler_top.sv =====
// Top level of the discrete table variate sampler: stream ports, APB register, cell row, sequencer.
// Path from accept to out_tvalid: load passes the compare in the addressed cell;
// cdf runs the sum wave through the cell row, then a one-bit-per-cycle division;
// sample runs the sum wave, a one-bit-per-cycle scale multiply, then the walk wave.
// One beat is in flight at a time: the next is taken the cycle after the result is loaded into
// the output register, and not while a finished result still waits on out.
// Synchronous active-low reset clears the table to zeros, sets entry_count to 1, empties the pipe.
module discrete_table_variate_sampler_top #(
  parameter int ENTRIES    = dtvs_pkg::ENTRIES_DEF,
  parameter int VALUE_BITS = dtvs_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = dtvs_pkg::FRAC_BITS_DEF,
  localparam int IN_DW  = ((dtvs_pkg::IDX_W + 2*VALUE_BITS + 2*FRAC_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((VALUE_BITS + FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata, lowest bit up: entry_index, entry_value, entry_weight, random_fraction, query_point
  input  logic [IN_DW-1:0]              in_tdata,
  // tuser: operation
  input  logic [dtvs_pkg::OP_W-1:0]     in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata, lowest bit up: sample_value, cdf_fraction
  output logic [OUT_DW-1:0]             out_tdata,
  // tuser: status
  output logic [dtvs_pkg::STATUS_W-1:0] out_tuser,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dtvs_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dtvs_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dtvs_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int IDX_W   = dtvs_pkg::IDX_W;
  localparam int ACC_W   = FRAC_BITS + $clog2(ENTRIES);
  localparam int SEL_W   = ($clog2(ENTRIES) > IDX_W) ? $clog2(ENTRIES) : IDX_W;
  localparam int OFF_VAL = IDX_W;
  localparam int OFF_WT  = OFF_VAL + VALUE_BITS;
  localparam int OFF_RF  = OFF_WT + FRAC_BITS;
  localparam int OFF_Q   = OFF_RF + FRAC_BITS;
  localparam int OUT_PAD = OUT_DW - VALUE_BITS - FRAC_BITS - 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  // --------------------------------------------------------------------------
  // Configuration register: entry_count, written on the APB access cycle.
  // --------------------------------------------------------------------------
  logic [dtvs_pkg::COUNT_W-1:0] entry_count_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == dtvs_pkg::CFG_IDX_ENTRY_COUNT) ?
                      dtvs_pkg::CFG_DW'(entry_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= dtvs_pkg::COUNT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == dtvs_pkg::CFG_IDX_ENTRY_COUNT)) begin
      entry_count_r <= cfg_pwdata[dtvs_pkg::COUNT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Input beat capture. Hold the fields for the whole operation.
  // --------------------------------------------------------------------------
  logic                      in_acc;
  logic [dtvs_pkg::OP_W-1:0] op_r;
  logic [IDX_W-1:0]          idx_r;
  logic [VALUE_BITS-1:0]     val_r;
  logic [FRAC_BITS-1:0]      wt_r;
  logic [FRAC_BITS-1:0]      rf_r;
  logic [VALUE_BITS-1:0]     q_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      idx_r <= in_tdata[IDX_W-1:0];
      val_r <= in_tdata[OFF_VAL +: VALUE_BITS];
      wt_r  <= in_tdata[OFF_WT +: FRAC_BITS];
      rf_r  <= in_tdata[OFF_RF +: FRAC_BITS];
      q_r   <= in_tdata[OFF_Q +: VALUE_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Cell row. A wave enters at the head and advances one cell per cycle; the
  // sum pass gathers total and cdf sums, the walk pass picks the sample.
  // --------------------------------------------------------------------------
  dtvs_pkg::wave_ctl_t head_ctl_r, head_ctl_nxt;
  logic [ACC_W-1:0]    head_acc_r, head_acc_nxt;

  dtvs_pkg::wave_ctl_t   ch_ctl   [0:ENTRIES];
  logic [ACC_W-1:0]      ch_acc   [0:ENTRIES];
  logic [ACC_W-1:0]      ch_csum  [0:ENTRIES];
  logic                  ch_found [0:ENTRIES];
  logic [VALUE_BITS-1:0] ch_val   [0:ENTRIES];
  logic [VALUE_BITS-1:0] tbl_val  [0:ENTRIES-1];
  logic [ENTRIES-1:0]    ld_ok;
  logic [ENTRIES-1:0]    act;
  logic                  ld_en;

  assign ld_en       = (state_r == S_LOAD);
  assign ch_ctl[0]   = head_ctl_r;
  assign ch_acc[0]   = head_acc_r;
  assign ch_csum[0]  = '0;
  assign ch_found[0] = 1'b0;
  assign ch_val[0]   = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v, right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = tbl_val[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner_r
      assign right_v = tbl_val[g+1];
    end

    // slots below the entry count take part in sample and cdf (a count past ENTRIES enables every slot)
    assign act[g] = (32'(entry_count_r) > 32'(g));

    dtvs_cell #(
      .CELL_ID   (g),
      .VALUE_BITS(VALUE_BITS),
      .FRAC_BITS (FRAC_BITS),
      .ACC_BITS  (ACC_W),
      .SEL_BITS  (SEL_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active     (act[g]),
      .ld_en      (ld_en),
      .ld_idx     (SEL_W'(idx_r)),
      .ld_value   (val_r),
      .ld_weight  (wt_r),
      .left_value (left_v),
      .right_value(right_v),
      .query      (q_r),
      .ctl_in     (ch_ctl[g]),
      .acc_in     (ch_acc[g]),
      .csum_in    (ch_csum[g]),
      .found_in   (ch_found[g]),
      .val_in     (ch_val[g]),
      .value      (tbl_val[g]),
      .ld_ok      (ld_ok[g]),
      .ctl_out    (ch_ctl[g+1]),
      .acc_out    (ch_acc[g+1]),
      .csum_out   (ch_csum[g+1]),
      .found_out  (ch_found[g+1]),
      .val_out    (ch_val[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Shared multiply/divide unit.
  // --------------------------------------------------------------------------
  dtvs_pkg::md_ctl_t    md_ctl;
  logic                 md_done;
  logic [ACC_W-1:0]     md_prod;
  logic [FRAC_BITS:0]   md_quot;
  logic                 tail_sum;
  logic                 tail_walk;

  assign tail_sum  = ch_ctl[ENTRIES].valid && !ch_ctl[ENTRIES].walk;
  assign tail_walk = ch_ctl[ENTRIES].valid && ch_ctl[ENTRIES].walk;

  assign md_ctl.start = (state_r == S_SUM) && tail_sum && (ch_acc[ENTRIES] != '0);
  assign md_ctl.div   = (op_r == dtvs_pkg::OP_CDF);

  dtvs_muldiv #(
    .FRAC_BITS(FRAC_BITS),
    .ACC_BITS (ACC_W)
  ) u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (md_ctl),
    .frac (rf_r),
    .num  (ch_csum[ENTRIES]),
    .den  (ch_acc[ENTRIES]),
    .done (md_done),
    .prod (md_prod),
    .quot (md_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer and result staging. A finished result waits in res_* until the
  // output register is free.
  // --------------------------------------------------------------------------
  logic [dtvs_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0]         res_sample_r, res_sample_nxt;
  logic [FRAC_BITS:0]            res_cdf_r, res_cdf_nxt;
  logic                          out_tvalid_r;
  logic [dtvs_pkg::STATUS_W-1:0] out_status_r;
  logic [VALUE_BITS-1:0]         out_sample_r;
  logic [FRAC_BITS:0]            out_cdf_r;
  logic                          out_free;
  logic                          out_load;

  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt      = state_r;
    head_ctl_nxt   = '0;
    head_acc_nxt   = head_acc_r;
    res_status_nxt = res_status_r;
    res_sample_nxt = res_sample_r;
    res_cdf_nxt    = res_cdf_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = dtvs_pkg::ST_OK;
          res_sample_nxt = '0;
          res_cdf_nxt    = '0;
          case (in_tuser)
            dtvs_pkg::OP_LOAD: state_nxt = S_LOAD;
            dtvs_pkg::OP_SAMPLE, dtvs_pkg::OP_CDF: begin
              // launch the sum wave
              head_ctl_nxt.valid = 1'b1;
              head_ctl_nxt.walk  = 1'b0;
              head_acc_nxt       = '0;
              state_nxt          = S_SUM;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        res_status_nxt = (|ld_ok) ? dtvs_pkg::ST_OK : dtvs_pkg::ST_REJECT;
        state_nxt      = S_DONE;
      end
      S_SUM: begin
        if (tail_sum) begin
          if (ch_acc[ENTRIES] == '0) begin
            res_status_nxt = dtvs_pkg::ST_ZERO;
            state_nxt      = S_DONE;
          end else if (op_r == dtvs_pkg::OP_CDF) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (md_done) begin
          // launch the walk wave with the scaled point
          head_ctl_nxt.valid = 1'b1;
          head_ctl_nxt.walk  = 1'b1;
          head_acc_nxt       = md_prod;
          state_nxt          = S_WALK;
        end
      end
      S_WALK: begin
        if (tail_walk) begin
          res_sample_nxt = ch_val[ENTRIES];
          state_nxt      = S_DONE;
        end
      end
      S_DIV: begin
        if (md_done) begin
          res_cdf_nxt = md_quot;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_ctl_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_ctl_r <= head_ctl_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_acc_r   <= head_acc_nxt;
    res_status_r <= res_status_nxt;
    res_sample_r <= res_sample_nxt;
    res_cdf_r    <= res_cdf_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_sample_r <= res_sample_r;
      out_cdf_r    <= res_cdf_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  if (OUT_PAD > 0) begin : g_out_pad
    assign out_tdata = {{OUT_PAD{1'b0}}, out_cdf_r, out_sample_r};
  end else begin : g_out_nopad
    assign out_tdata = {out_cdf_r, out_sample_r};
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_wave_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    ch_ctl[ENTRIES].valid |-> (state_r == S_SUM) || (state_r == S_WALK))
    else $error("wave left the cell row outside a pass");

  a_md_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_MUL) || (state_r == S_DIV))
    else $error("multiply/divide finished while not awaited");

  a_load_goes_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == dtvs_pkg::OP_LOAD)) |=> (state_r == S_LOAD))
    else $error("load beat did not enter the load cycle");

  a_zero_total_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_status_r == dtvs_pkg::ST_ZERO)) |->
      (out_sample_r == '0) && (out_cdf_r == '0))
    else $error("zero-total result carries data");

  a_load_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ld_ok))
    else $error("load accepted in more than one slot");

endmodule
